// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the balancer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property checked on every clock edge outside reset
`define RRAB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication checked outside reset
`define RRAB_ASSERT_IMP(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

// ===== rtl/core/rrab_pkg.sv =====
// shared types, constants and codes of the round-robin autoscale balancer
package rrab_pkg;

  localparam int SERVERS_DEF = 3;
  localparam int QUEUE_DEPTH = 2;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 2;
  localparam int LOAD_W    = 8;
  localparam int TOTAL_W   = 12;
  localparam int MASK_W    = 3;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [LOAD_W-1:0]  LOAD_MAX  = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  localparam logic [CFG_W-1:0] CAPACITY_RST  = 8'd10;
  localparam logic [CFG_W-1:0] HEADROOM_RST  = 8'd1;
  localparam logic [CFG_W-1:0] LOW_MARK_RST  = 8'd2;
  localparam logic [CFG_W-1:0] HIGH_MARK_RST = 8'd5;

  typedef enum logic [OP_W-1:0] {
    OP_ARRIVAL,
    OP_ESTABLISHED,
    OP_CLOSED,
    OP_TICK
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAPACITY,
    REG_HEADROOM,
    REG_LOW_MARK,
    REG_HIGH_MARK
  } reg_idx_t;

  // work class handed from front to back
  typedef enum logic [2:0] {
    CL_ARRIVE,
    CL_INC,
    CL_DEC,
    CL_TICK,
    CL_NOP
  } class_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_ARR_WAKE,
    ST_ARR_PICK,
    ST_DSC_OUTER,
    ST_DSC_INNER,
    ST_DSC_APPLY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [CFG_W-1:0] capacity;
    logic [CFG_W-1:0] headroom;
    logic [CFG_W-1:0] low_mark;
    logic [CFG_W-1:0] high_mark;
  } cfg_t;

  typedef struct packed {
    logic               granted;
    logic [IDX_W-1:0]   chosen_server;
    logic               woke;
    logic [IDX_W-1:0]   woke_server;
    logic               retired;
    logic [IDX_W-1:0]   retired_server;
    logic [IDX_W-1:0]   receiver_server;
    logic [TOTAL_W-1:0] total_load;
    logic [MASK_W-1:0]  active_mask;
  } result_t;

endpackage

// ===== rtl/core/rrab_if.sv =====
// valid/ready channel interfaces: event input, result output, register writes
interface rrab_in_if;
  import rrab_pkg::*;
  logic            valid;
  logic            ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] server;
  modport source (output valid, output op, output server, input ready);
  modport sink   (input valid, input op, input server, output ready);
endinterface

interface rrab_out_if;
  import rrab_pkg::*;
  logic               valid;
  logic               ready;
  logic               granted;
  logic [IDX_W-1:0]   chosen_server;
  logic               woke;
  logic [IDX_W-1:0]   woke_server;
  logic               retired;
  logic [IDX_W-1:0]   retired_server;
  logic [IDX_W-1:0]   receiver_server;
  logic [TOTAL_W-1:0] total_load;
  logic [MASK_W-1:0]  active_mask;
  modport source (output valid, output granted, output chosen_server, output woke,
                  output woke_server, output retired, output retired_server,
                  output receiver_server, output total_load, output active_mask,
                  input ready);
  modport sink   (input valid, input granted, input chosen_server, input woke,
                  input woke_server, input retired, input retired_server,
                  input receiver_server, input total_load, input active_mask,
                  output ready);
endinterface

interface rrab_cfg_if;
  import rrab_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/round_robin_autoscale_balancer_core.sv =====
// top level of the round-robin autoscale balancer: config registers and block wiring
//
// Channels: in_ch takes one event beat (op, server); out_ch returns exactly
// one result beat per event, in order; cfg_ch writes capacity, headroom,
// low_mark and high_mark by index and is always ready. Write registers only
// while no event is in flight.
// Events go through a small queue into a sequencer that owns the server
// state. Sequencer steps per event, ahead of the result register:
//   established / closed: a count update, none when the server index is out of range
//   arrival: a wake check, then round-robin probes from the pointer to an active server
//   descale tick: straight to the result with a single active server, else
//   a donor scan over the servers, with a full receiver scan and an apply
//   step for each underused server until one is retired
// The sequencer handles one event at a time; the queue keeps taking beats
// meanwhile.
// Reset (rst_n low at a clock edge) activates server 0 only, clears all
// loads, total and pointer, empties the queue and output, and loads the
// register defaults 10, 1, 2, 5.
// A stalled receiver holds the result register; the sequencer then waits and
// the queue fills, after which in_ch drops ready.
module round_robin_autoscale_balancer_core #(
  parameter int SERVERS = rrab_pkg::SERVERS_DEF,
  parameter int QDEPTH  = rrab_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  rrab_in_if.sink     in_ch,
  rrab_out_if.source  out_ch,
  rrab_cfg_if.sink    cfg_ch
);
  import rrab_pkg::*;

  localparam int SW      = $clog2(SERVERS);
  localparam int ENTRY_W = $bits(class_t) + SW;

  cfg_t               cfg_r;
  logic               push, push_ready, pop, pop_valid;
  logic [ENTRY_W-1:0] push_data, pop_data;

  // configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capacity  <= CAPACITY_RST;
      cfg_r.headroom  <= HEADROOM_RST;
      cfg_r.low_mark  <= LOW_MARK_RST;
      cfg_r.high_mark <= HIGH_MARK_RST;
    end else if (cfg_ch.valid) begin
      case (reg_idx_t'(cfg_ch.index))
        REG_CAPACITY:  cfg_r.capacity  <= cfg_ch.data;
        REG_HEADROOM:  cfg_r.headroom  <= cfg_ch.data;
        REG_LOW_MARK:  cfg_r.low_mark  <= cfg_ch.data;
        REG_HIGH_MARK: cfg_r.high_mark <= cfg_ch.data;
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  rrab_front #(.SERVERS(SERVERS)) u_front (
    .in_ch      (in_ch),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready)
  );

  rrab_queue #(.DATA_W(ENTRY_W), .DEPTH(QDEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data)
  );

  rrab_back #(.SERVERS(SERVERS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_valid (pop_valid),
    .q_data  (pop_data),
    .q_pop   (pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/core/rrab_front.sv =====
// front end: takes event beats, sorts them into work classes for the back end
module rrab_front #(
  parameter int SERVERS = rrab_pkg::SERVERS_DEF,
  localparam int SW = $clog2(SERVERS),
  localparam int ENTRY_W = $bits(rrab_pkg::class_t) + SW
) (
  rrab_in_if.sink              in_ch,
  output logic                 push,
  output logic [ENTRY_W-1:0]   push_data,
  input  logic                 push_ready
);
  import rrab_pkg::*;

  class_t        cls;
  logic          in_range;
  logic [SW-1:0] idx;

  // accept whenever the queue has room
  assign in_ch.ready = push_ready;
  assign push        = in_ch.valid && push_ready;

  // counter updates aimed at a missing server turn into no-ops
  assign in_range = (int'(in_ch.server) < SERVERS);
  assign idx      = SW'(in_ch.server);

  always_comb begin
    case (op_t'(in_ch.op))
      OP_ARRIVAL:     cls = CL_ARRIVE;
      OP_ESTABLISHED: cls = in_range ? CL_INC : CL_NOP;
      OP_CLOSED:      cls = in_range ? CL_DEC : CL_NOP;
      OP_TICK:        cls = CL_TICK;
      default:        cls = CL_NOP;
    endcase
  end

  assign push_data = {cls, idx};

endmodule

// ===== rtl/core/rrab_queue.sv =====
// short fifo between the front and back ends
module rrab_queue #(
  parameter int DATA_W = 4,
  parameter int DEPTH  = rrab_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              push_ready,
  input  logic              pop,
  output logic              pop_valid,
  output logic [DATA_W-1:0] pop_data
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]     cnt_r;
  logic              do_push, do_pop;

  assign push_ready = (cnt_r != CW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/rrab_back.sv =====
// back end: server state, scan sequencer for each work class, result register
`include "assert_macros.svh"

module rrab_back #(
  parameter int SERVERS = rrab_pkg::SERVERS_DEF,
  localparam int SW = $clog2(SERVERS),
  localparam int ENTRY_W = $bits(rrab_pkg::class_t) + SW
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rrab_pkg::cfg_t       cfg,
  input  logic                 q_valid,
  input  logic [ENTRY_W-1:0]   q_data,
  output logic                 q_pop,
  rrab_out_if.source           out_ch
);
  import rrab_pkg::*;

  localparam int CW   = $clog2(SERVERS + 1);
  localparam int PW   = SW + 1;
  localparam int TH_W = (LOAD_W + CW > TOTAL_W + 1) ? LOAD_W + CW : TOTAL_W + 1;
  localparam logic [SW-1:0] LAST = SW'(SERVERS - 1);

  state_t state_r, state_nxt;

  // server state
  logic [SERVERS-1:0] active_r;
  logic [LOAD_W-1:0]  load_r [SERVERS];
  logic [TOTAL_W-1:0] total_r;
  logic [IDX_W-1:0]   rr_r;
  logic [CW-1:0]      act_cnt_r;

  // per-item scratch
  class_t            cls_r;
  logic [SW-1:0]     srv_r, i_r, j_r, k_r, best_r;
  logic              found_r;
  logic [LOAD_W-1:0] min_r, li_r;
  logic              granted_r, woke_r, retired_r;
  logic [IDX_W-1:0]  chosen_r, woke_srv_r, ret_srv_r, recv_r;

  // result register
  logic    out_valid_r;
  result_t out_r;

  class_t            q_cls;
  logic [SW-1:0]     q_idx;
  logic [SW-1:0]     rd_addr;
  logic [LOAD_W-1:0] rd_load;
  logic [TH_W-1:0]   need, have;
  logic              scale_up, wake_any;
  logic [SW-1:0]     wake_idx;
  logic [PW-1:0]     pick_sum, pick_w, rr_next_w;
  logic [SW-1:0]     pick_idx;
  logic              pick_hit;
  logic              under, cand;
  logic [LOAD_W:0]   merge_sum;
  logic [LOAD_W-1:0] merge_load;
  logic              out_free, out_load;
  logic [SERVERS+MASK_W-1:0] act_pad;

  assign q_cls = class_t'(q_data[ENTRY_W-1:SW]);
  assign q_idx = q_data[SW-1:0];

  // single load read port, address chosen by the sequencer step
  always_comb begin
    case (state_r)
      ST_DSC_OUTER: rd_addr = i_r;
      ST_DSC_INNER: rd_addr = j_r;
      default:      rd_addr = srv_r;
    endcase
  end
  assign rd_load = load_r[rd_addr];

  // scale-up check: total + headroom >= capacity * active
  assign need     = TH_W'(cfg.capacity) * TH_W'(act_cnt_r);
  assign have     = TH_W'(total_r) + TH_W'(cfg.headroom);
  assign scale_up = (act_cnt_r != '0) && (have >= need);

  // lowest inactive server
  always_comb begin
    wake_any = 1'b0;
    wake_idx = '0;
    for (int s = SERVERS - 1; s >= 0; s--) begin
      if (!active_r[s]) begin
        wake_any = 1'b1;
        wake_idx = SW'(s);
      end
    end
  end

  // round-robin probe: one candidate per cycle starting at the pointer
  assign pick_sum  = PW'(rr_r) + PW'(k_r);
  assign pick_w    = (pick_sum >= PW'(SERVERS)) ? pick_sum - PW'(SERVERS) : pick_sum;
  assign pick_idx  = SW'(pick_w);
  assign pick_hit  = active_r[pick_idx];
  assign rr_next_w = (pick_w == PW'(SERVERS - 1)) ? '0 : pick_w + 1'b1;

  // descale: donor test on the outer scan, receiver test on the inner scan
  assign under = active_r[i_r] && (rd_load < cfg.low_mark);
  assign cand  = active_r[j_r] && (j_r != i_r) && (rd_load >= cfg.low_mark) &&
                 (rd_load < cfg.high_mark) && (rd_load < min_r);

  // min_r holds the receiver's own load once a receiver is found
  assign merge_sum  = {1'b0, min_r} + {1'b0, li_r};
  assign merge_load = merge_sum[LOAD_W] ? LOAD_MAX : merge_sum[LOAD_W-1:0];

  assign out_free = !out_valid_r || out_ch.ready;
  assign act_pad  = {{MASK_W{1'b0}}, active_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_cls)
            CL_ARRIVE:     state_nxt = ST_ARR_WAKE;
            CL_INC, CL_DEC: state_nxt = ST_COUNT;
            CL_TICK:       state_nxt = (act_cnt_r > CW'(1)) ? ST_DSC_OUTER : ST_FINISH;
            default:       state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_COUNT:     state_nxt = ST_FINISH;
      ST_ARR_WAKE:  state_nxt = (act_cnt_r == '0) ? ST_FINISH : ST_ARR_PICK;
      ST_ARR_PICK:  state_nxt = (pick_hit || k_r == LAST) ? ST_FINISH : ST_ARR_PICK;
      ST_DSC_OUTER: begin
        if (under) begin
          state_nxt = ST_DSC_INNER;
        end else if (i_r == LAST) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DSC_INNER: state_nxt = (j_r == LAST) ? ST_DSC_APPLY : ST_DSC_INNER;
      ST_DSC_APPLY: state_nxt = (found_r || i_r == LAST) ? ST_FINISH : ST_DSC_OUTER;
      ST_FINISH:    state_nxt = out_free ? ST_IDLE : ST_FINISH;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    q_pop    = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:   q_pop    = q_valid;
      ST_FINISH: out_load = out_free;
      default: begin
        q_pop    = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // server state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= SERVERS'(1);
      total_r   <= '0;
      rr_r      <= '0;
      act_cnt_r <= CW'(1);
      for (int s = 0; s < SERVERS; s++) begin
        load_r[s] <= '0;
      end
    end else begin
      case (state_r)
        ST_COUNT: begin
          if (cls_r == CL_INC) begin
            if (rd_load != LOAD_MAX) load_r[srv_r] <= rd_load + 1'b1;
            if (total_r != TOTAL_MAX) total_r <= total_r + 1'b1;
          end else begin
            if (rd_load != '0) load_r[srv_r] <= rd_load - 1'b1;
            if (total_r != '0) total_r <= total_r - 1'b1;
          end
        end
        ST_ARR_WAKE: begin
          if (scale_up && wake_any) begin
            active_r[wake_idx] <= 1'b1;
            act_cnt_r          <= act_cnt_r + 1'b1;
          end
        end
        ST_ARR_PICK: begin
          if (pick_hit) rr_r <= IDX_W'(rr_next_w);
        end
        ST_DSC_APPLY: begin
          if (found_r) begin
            load_r[best_r] <= merge_load;
            load_r[i_r]    <= '0;
            active_r[i_r]  <= 1'b0;
            act_cnt_r      <= act_cnt_r - 1'b1;
          end
        end
        default: begin
          active_r <= active_r;
        end
      endcase
    end
  end

  // per-item scratch and result fields
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          cls_r      <= q_cls;
          srv_r      <= q_idx;
          i_r        <= '0;
          k_r        <= '0;
          granted_r  <= 1'b0;
          chosen_r   <= '0;
          woke_r     <= 1'b0;
          woke_srv_r <= '0;
          retired_r  <= 1'b0;
          ret_srv_r  <= '0;
          recv_r     <= '0;
        end
      end
      ST_ARR_WAKE: begin
        if (scale_up && wake_any) begin
          woke_r     <= 1'b1;
          woke_srv_r <= IDX_W'(wake_idx);
        end
      end
      ST_ARR_PICK: begin
        if (pick_hit) begin
          granted_r <= 1'b1;
          chosen_r  <= IDX_W'(pick_idx);
        end
        k_r <= k_r + 1'b1;
      end
      ST_DSC_OUTER: begin
        if (under) begin
          li_r    <= rd_load;
          j_r     <= '0;
          found_r <= 1'b0;
          min_r   <= cfg.capacity;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      ST_DSC_INNER: begin
        if (cand) begin
          min_r   <= rd_load;
          best_r  <= j_r;
          found_r <= 1'b1;
        end
        j_r <= j_r + 1'b1;
      end
      ST_DSC_APPLY: begin
        if (found_r) begin
          retired_r <= 1'b1;
          ret_srv_r <= IDX_W'(i_r);
          recv_r    <= IDX_W'(best_r);
        end else begin
          i_r <= i_r + 1'b1;
        end
      end
      default: begin
        cls_r <= cls_r;
      end
    endcase
  end

  // output register: valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.granted         <= granted_r;
      out_r.chosen_server   <= chosen_r;
      out_r.woke            <= woke_r;
      out_r.woke_server     <= woke_srv_r;
      out_r.retired         <= retired_r;
      out_r.retired_server  <= ret_srv_r;
      out_r.receiver_server <= recv_r;
      out_r.total_load      <= total_r;
      out_r.active_mask     <= act_pad[MASK_W-1:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted         = out_r.granted;
  assign out_ch.chosen_server   = out_r.chosen_server;
  assign out_ch.woke            = out_r.woke;
  assign out_ch.woke_server     = out_r.woke_server;
  assign out_ch.retired         = out_r.retired;
  assign out_ch.retired_server  = out_r.retired_server;
  assign out_ch.receiver_server = out_r.receiver_server;
  assign out_ch.total_load      = out_r.total_load;
  assign out_ch.active_mask     = out_r.active_mask;

  // checks
  `RRAB_ASSERT(a_act_cnt_match, clk, rst_n, act_cnt_r == CW'($countones(active_r)), "active count out of step with flags")
  `RRAB_ASSERT(a_one_active, clk, rst_n, act_cnt_r != '0, "no server left active")
  `RRAB_ASSERT_IMP(a_retire_leaves_one, clk, rst_n, state_r == ST_DSC_APPLY && found_r, act_cnt_r > CW'(1) && active_r[best_r] && best_r != i_r, "retire would empty the pool or hit a bad receiver")

endmodule
